/* hdl/nkx_pkg.sv */
// Shared constants, request types and fixed-point helpers for the n/k extraction block.
`default_nettype none
package nkx_pkg;

	localparam int MAX_ITERATIONS = 64;
	localparam int CORDIC_STAGES  = 24;
	localparam int STAGE_W        = $clog2(CORDIC_STAGES);

	localparam logic [6:0]         ITER_LIMIT = 7'(MAX_ITERATIONS);
	localparam logic signed [31:0] ONE_Q16    = 32'sd65536;
	localparam logic signed [31:0] TWO_Q16    = 32'sd131072;
	localparam logic [29:0]        C1_Q32     = 30'd683552635;
	localparam logic [26:0]        CDC_Q32    = 27'd128758825;
	localparam logic [23:0]        LN2_Q24    = 24'd11629080;
	localparam logic [29:0]        KINV_Q30   = 30'd652032874;
	localparam logic signed [33:0] PI_Q30     = 34'sd3373259426;

	typedef enum logic [2:0] {
		REG_DC_TERM         = 3'd0,
		REG_THICKNESS       = 3'd1,
		REG_AMPLITUDE_SCALE = 3'd2,
		REG_PHASE_OFFSET    = 3'd3,
		REG_ITERATION_COUNT = 3'd4
	} reg_index_t;

	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [63:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        start;
		logic [63:0] value;
		logic [5:0]  frac_bits;
	} log_req_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) begin
			return 32'sh7FFFFFFF;
		end else if (v < -66'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	// Q0.30 arctangent of 2^-i, truncated
	function automatic logic [29:0] atan_q30(input logic [4:0] i);
		logic [29:0] a;
		case (i)
			5'd0:  a = 30'h3243F6A8;
			5'd1:  a = 30'h1DAC6705;
			5'd2:  a = 30'h0FADBAFC;
			5'd3:  a = 30'h07F56EA6;
			5'd4:  a = 30'h03FEAB76;
			5'd5:  a = 30'h01FFD55B;
			5'd6:  a = 30'h00FFFAAA;
			5'd7:  a = 30'h007FFF55;
			5'd8:  a = 30'h003FFFEA;
			5'd9:  a = 30'h001FFFFD;
			5'd10: a = 30'h000FFFFF;
			5'd11: a = 30'h0007FFFF;
			5'd12: a = 30'h0003FFFF;
			5'd13: a = 30'h0001FFFF;
			5'd14: a = 30'h0000FFFF;
			5'd15: a = 30'h00007FFF;
			5'd16: a = 30'h00003FFF;
			5'd17: a = 30'h00001FFF;
			5'd18: a = 30'h00000FFF;
			5'd19: a = 30'h000007FF;
			5'd20: a = 30'h000003FF;
			5'd21: a = 30'h000001FF;
			5'd22: a = 30'h000000FF;
			5'd23: a = 30'h0000007F;
			5'd24: a = 30'h0000003F;
			5'd25: a = 30'h0000001F;
			5'd26: a = 30'h0000000F;
			5'd27: a = 30'h00000007;
			5'd28: a = 30'h00000003;
			5'd29: a = 30'h00000001;
			default: a = 30'h0;
		endcase
		return a;
	endfunction

endpackage
`default_nettype wire

/* hdl/nkx_div.sv */
// Restoring unsigned 64/64 divider, one quotient bit per cycle.
`default_nettype none
module nkx_div (
	input  logic             clk,
	input  logic             arst_n,
	input  nkx_pkg::div_req_t req,
	output logic             busy,
	output logic [63:0]      quot
);

	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [63:0] dsr_q;
	logic [64:0] trial;
	logic [64:0] diff;
	logic        ge;

	assign trial = {rem_q, quo_q[63]};
	assign diff  = trial - {1'b0, dsr_q};
	assign ge    = trial >= {1'b0, dsr_q};
	assign busy  = busy_q;
	assign quot  = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == 6'd63) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[63:0] : trial[63:0];
			quo_q <= {quo_q[62:0], ge};
		end
	end

endmodule
`default_nettype wire

/* hdl/nkx_log.sv */
// Natural log in Q16.16: leading-one search, 30 squaring steps, then scale by ln2.
`default_nettype none
module nkx_log (
	input  logic                clk,
	input  logic                arst_n,
	input  nkx_pkg::log_req_t   req,
	output logic                busy,
	output logic signed [31:0]  result
);

	typedef enum logic [6:0] {
		L_IDLE = 7'b0000001,
		L_NORM = 7'b0000010,
		L_LOAD = 7'b0000100,
		L_SQ   = 7'b0001000,
		L_M1   = 7'b0010000,
		L_M2   = 7'b0100000,
		L_FIN  = 7'b1000000
	} lstate_t;

	localparam logic [63:0] BIAS = 64'(64'd64 * 64'(nkx_pkg::LN2_Q24)) << 30;

	lstate_t            state_q;
	logic [63:0]        w_q;
	logic [5:0]         lead_q;
	logic [5:0]         fb_q;
	logic [2:0]         step_q;
	logic [30:0]        m_q;
	logic [29:0]        frac_q;
	logic [4:0]         it_q;
	logic [53:0]        p1_q;
	logic [31:0]        p2_q;
	logic signed [31:0] res_q;

	logic [6:0]  sh;
	logic        top_zero;
	logic [30:0] mul_a;
	logic [30:0] mul_b;
	logic [61:0] prod;
	logic [31:0] sqt;
	logic [6:0]  expo;
	logic [63:0] total;

	assign sh       = 7'd32 >> step_q;
	assign top_zero = (w_q >> (7'd64 - sh)) == 64'd0;
	assign expo     = 7'({1'b0, lead_q}) - 7'({1'b0, fb_q}) + 7'd64;
	assign sqt      = prod[61:30];
	assign total    = 64'({p2_q, 30'b0}) + 64'(p1_q) - BIAS;
	assign busy     = state_q != L_IDLE;
	assign result   = res_q;

	always_comb begin
		case (state_q)
			L_M1: begin
				mul_a = 31'(frac_q);
				mul_b = 31'(nkx_pkg::LN2_Q24);
			end
			L_M2: begin
				mul_a = 31'(expo);
				mul_b = 31'(nkx_pkg::LN2_Q24);
			end
			default: begin
				mul_a = m_q;
				mul_b = m_q;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			step_q  <= '0;
			it_q    <= '0;
		end else begin
			case (state_q)
				L_IDLE: begin
					if (req.start) begin
						state_q <= L_NORM;
						step_q  <= '0;
					end
				end
				L_NORM: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd5) begin
						state_q <= L_LOAD;
					end
				end
				L_LOAD: begin
					it_q    <= '0;
					state_q <= L_SQ;
				end
				L_SQ: begin
					it_q <= it_q + 5'd1;
					if (it_q == 5'd29) begin
						state_q <= L_M1;
					end
				end
				L_M1: state_q <= L_M2;
				L_M2: state_q <= L_FIN;
				L_FIN: state_q <= L_IDLE;
				default: state_q <= L_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			L_IDLE: begin
				if (req.start) begin
					w_q    <= req.value;
					fb_q   <= req.frac_bits;
					lead_q <= 6'd63;
				end
			end
			L_NORM: begin
				if (top_zero) begin
					w_q    <= w_q << sh;
					lead_q <= lead_q - sh[5:0];
				end
			end
			L_LOAD: begin
				m_q    <= w_q[63:33];
				frac_q <= '0;
			end
			L_SQ: begin
				// renormalize the square back below 2.0
				m_q    <= sqt[31] ? sqt[31:1] : sqt[30:0];
				frac_q <= {frac_q[28:0], sqt[31]};
			end
			L_M1: p1_q <= prod[53:0];
			L_M2: p2_q <= prod[31:0];
			L_FIN: res_q <= 32'($signed(total) >>> 38);
			default: ;
		endcase
	end

endmodule
`default_nettype wire

/* hdl/nk_iterative_extraction.sv */
// Top level: fixed-point iterative n/k extraction with a shared multiplier and CORDIC.
//
//  channel  direction  handshake               payload
//  cfg      in         cfg_valid / cfg_ready   cfg_index, cfg_data
//  in       in         in_valid / in_ready     frequency, amplitude, phase, n_start, k_start
//  out      out        out_valid / out_ready   n_out, k_out, fell_back
//
// One point's setup runs two divisions and a logarithm; each iteration then runs the
// 24-step CORDIC and two logarithms, which dominate its length.
// in_ready is high only while no point is in work; the result register lets the
// next point enter while a result waits. Configuration writes are always taken.
// Reset clears the sequencer, the output valid and the registers to their defaults.
`default_nettype none
module nk_iterative_extraction (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [30:0]        frequency,
	input  logic [30:0]        amplitude,
	input  logic signed [31:0] phase,
	input  logic signed [31:0] n_start,
	input  logic signed [31:0] k_start,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] n_out,
	output logic signed [31:0] k_out,
	output logic               fell_back
);

	localparam int NS = 31;

	typedef enum logic [NS-1:0] {
		S_IDLE  = 31'd1 << 0,
		S_TF    = 31'd1 << 1,
		S_AS    = 31'd1 << 2,
		S_DC    = 31'd1 << 3,
		S_BDIV  = 31'd1 << 4,
		S_BWAIT = 31'd1 << 5,
		S_FWAIT = 31'd1 << 6,
		S_CF    = 31'd1 << 7,
		S_CF2   = 31'd1 << 8,
		S_PCHK  = 31'd1 << 9,
		S_P0    = 31'd1 << 10,
		S_P1    = 31'd1 << 11,
		S_P2    = 31'd1 << 12,
		S_P3    = 31'd1 << 13,
		S_P4    = 31'd1 << 14,
		S_P5    = 31'd1 << 15,
		S_P6    = 31'd1 << 16,
		S_P7    = 31'd1 << 17,
		S_P8    = 31'd1 << 18,
		S_COR   = 31'd1 << 19,
		S_XM0   = 31'd1 << 20,
		S_XM1   = 31'd1 << 21,
		S_XM2   = 31'd1 << 22,
		S_LW1   = 31'd1 << 23,
		S_LW2   = 31'd1 << 24,
		S_SN0   = 31'd1 << 25,
		S_SN1   = 31'd1 << 26,
		S_SN2   = 31'd1 << 27,
		S_SN3   = 31'd1 << 28,
		S_SN4   = 31'd1 << 29,
		S_FIN   = 31'd1 << 30
	} state_t;

	// magnitude-and-sign product with the Q.24 factor, saturated
	function automatic logic signed [31:0] s24(input logic [47:0] r, input logic neg);
		if (!neg) begin
			return (r > 48'd2147483647) ? 32'sh7FFFFFFF : r[31:0];
		end
		return (r > 48'd2147483648) ? 32'sh80000000 : 32'(-r[31:0]);
	endfunction

	state_t state_q;

	// configuration
	logic signed [31:0] dc_q;
	logic [30:0]        thick_q;
	logic [30:0]        ascale_q;
	logic signed [31:0] poff_q;
	logic [6:0]         iter_q;

	// item state
	logic [30:0]        fq_q;
	logic [30:0]        amp_q;
	logic signed [31:0] ph_sum_q;
	logic signed [31:0] n_q;
	logic signed [31:0] k_q;
	logic [6:0]         cnt_q;
	logic [6:0]         pass_q;
	logic               bad_q;
	logic               dneg_q;
	logic signed [31:0] base_q;
	logic [61:0]        tf_q;
	logic [61:0]        as_q;
	logic [36:0]        cf24_q;
	logic signed [31:0] ln_amp_q;
	logic signed [31:0] sq_q;
	logic signed [31:0] kk_q;
	logic signed [31:0] dd_q;
	logic signed [31:0] a_q;
	logic signed [31:0] pr_q;
	logic signed [31:0] b_q;
	logic signed [31:0] qi_q;
	logic signed [35:0] cx_q;
	logic signed [35:0] cy_q;
	logic signed [33:0] cz_q;
	logic [nkx_pkg::STAGE_W-1:0] stage_q;
	logic [63:0]        acc_q;
	logic [63:0]        xmk_q;
	logic signed [31:0] lndd_q;
	logic signed [31:0] argd_q;
	logic signed [31:0] kd_q;
	logic signed [65:0] prod_q;

	// output register
	logic               out_valid_q;
	logic signed [31:0] n_out_q;
	logic signed [31:0] k_out_q;
	logic               fb_q;

	// shared units
	nkx_pkg::div_req_t  div_req;
	nkx_pkg::log_req_t  log_req;
	logic               div_busy;
	logic [63:0]        div_quot;
	logic               log_busy;
	logic signed [31:0] log_res;

	logic signed [32:0] ma;
	logic signed [32:0] mb;
	logic signed [31:0] onep;
	logic signed [31:0] twon;
	logic signed [31:0] mulq_p;
	logic [30:0]        ftq;
	logic signed [32:0] arg_mag;
	logic signed [32:0] kd_mag;
	logic signed [32:0] cf_lo;
	logic signed [32:0] cf_hi;
	logic [47:0]        r48;
	logic [63:0]        dc_mag;
	logic               in_bad;
	logic               p8_bad;
	logic               fin_go;
	logic signed [35:0] cxs;
	logic signed [35:0] cys;
	logic signed [33:0] cat;

	assign cfg_ready = 1'b1;
	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;
	assign n_out     = n_out_q;
	assign k_out     = k_out_q;
	assign fell_back = fb_q;

	assign onep    = nkx_pkg::sat32(66'(n_q) + 66'(nkx_pkg::ONE_Q16));
	assign twon    = nkx_pkg::sat32(66'(n_q) + 66'(nkx_pkg::TWO_Q16));
	assign mulq_p  = nkx_pkg::sat32(prod_q >>> 16);
	assign ftq     = (div_quot > 64'd2147483647) ? 31'h7FFFFFFF : div_quot[30:0];
	assign arg_mag = argd_q[31] ? -33'(argd_q) : 33'(argd_q);
	assign kd_mag  = kd_q[31] ? -33'(kd_q) : 33'(kd_q);
	assign cf_lo   = $signed({1'b0, cf24_q[31:0]});
	assign cf_hi   = $signed(33'(cf24_q[36:32]));
	assign r48     = {prod_q[39:0], 8'b0} + acc_q[47:0];
	assign dc_mag  = prod_q[65] ? 64'(-prod_q) : prod_q[63:0];
	assign in_bad  = (tf_q == 62'd0) || (as_q == 62'd0);
	assign p8_bad  = (dd_q <= 32'sd0) || (pr_q == 32'sd0 && qi_q == 32'sd0);
	assign fin_go  = !out_valid_q || out_ready;

	assign cxs = cx_q >>> stage_q;
	assign cys = cy_q >>> stage_q;
	assign cat = $signed(34'(nkx_pkg::atan_q30(5'(stage_q))));

	// operand select for the shared multiplier
	always_comb begin
		case (state_q)
			S_TF: begin
				ma = $signed(33'(thick_q));
				mb = $signed(33'(fq_q));
			end
			S_AS: begin
				ma = $signed(33'(amp_q));
				mb = $signed(33'(ascale_q));
			end
			S_DC: begin
				ma = 33'(dc_q);
				mb = $signed(33'(nkx_pkg::CDC_Q32));
			end
			S_CF: begin
				ma = $signed(33'(ftq));
				mb = $signed(33'(nkx_pkg::C1_Q32));
			end
			S_P0: begin
				ma = 33'(onep);
				mb = 33'(onep);
			end
			S_P1: begin
				ma = 33'(k_q);
				mb = 33'(k_q);
			end
			S_P2: begin
				ma = 33'(n_q);
				mb = 33'(sq_q);
			end
			S_P3: begin
				ma = 33'(kk_q);
				mb = 33'(twon);
			end
			S_P4: begin
				ma = 33'(n_q);
				mb = 33'(n_q);
			end
			S_P6: begin
				ma = 33'(k_q);
				mb = 33'(b_q);
			end
			S_XM0: begin
				ma = $signed({1'b0, cx_q[31:0]});
				mb = $signed(33'(nkx_pkg::KINV_Q30));
			end
			S_XM1: begin
				ma = $signed(33'(cx_q[35:32]));
				mb = $signed(33'(nkx_pkg::KINV_Q30));
			end
			S_SN0: begin
				ma = cf_lo;
				mb = arg_mag;
			end
			S_SN1: begin
				ma = cf_hi;
				mb = arg_mag;
			end
			S_SN2: begin
				ma = cf_lo;
				mb = kd_mag;
			end
			S_SN3: begin
				ma = cf_hi;
				mb = kd_mag;
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	always_comb begin
		div_req = '0;
		log_req = '0;
		case (state_q)
			S_BDIV: begin
				div_req.start    = 1'b1;
				div_req.dividend = dc_mag;
				div_req.divisor  = 64'({thick_q, 16'b0});
			end
			S_BWAIT: begin
				if (!div_busy && !in_bad) begin
					div_req.start     = 1'b1;
					div_req.dividend  = 64'd1 << 48;
					div_req.divisor   = 64'(tf_q);
					log_req.start     = 1'b1;
					log_req.value     = 64'(as_q);
					log_req.frac_bits = 6'd32;
				end
			end
			S_P8: begin
				if (!p8_bad) begin
					log_req.start     = 1'b1;
					log_req.value     = 64'(unsigned'(dd_q));
					log_req.frac_bits = 6'd16;
				end
			end
			S_LW1: begin
				if (!log_busy) begin
					log_req.start     = 1'b1;
					log_req.value     = xmk_q;
					log_req.frac_bits = 6'd44;
				end
			end
			default: ;
		endcase
	end

	nkx_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.busy   (div_busy),
		.quot   (div_quot)
	);

	nkx_log u_log (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (log_req),
		.busy   (log_busy),
		.result (log_res)
	);

	// sequencer, configuration and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			dc_q        <= '0;
			thick_q     <= 31'd65536;
			ascale_q    <= 31'd65536;
			poff_q      <= '0;
			iter_q      <= 7'd8;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					nkx_pkg::REG_DC_TERM:         dc_q     <= cfg_data;
					nkx_pkg::REG_THICKNESS:       thick_q  <= cfg_data[30:0];
					nkx_pkg::REG_AMPLITUDE_SCALE: ascale_q <= cfg_data[30:0];
					nkx_pkg::REG_PHASE_OFFSET:    poff_q   <= cfg_data;
					nkx_pkg::REG_ITERATION_COUNT: iter_q   <= cfg_data[6:0];
					default: ;
				endcase
			end
			if (state_q == S_FIN && fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE:  if (in_valid) state_q <= S_TF;
				S_TF:    state_q <= S_AS;
				S_AS:    state_q <= S_DC;
				S_DC:    state_q <= S_BDIV;
				S_BDIV:  state_q <= S_BWAIT;
				S_BWAIT: begin
					if (!div_busy) begin
						state_q <= in_bad ? S_FIN : S_FWAIT;
					end
				end
				S_FWAIT: if (!div_busy && !log_busy) state_q <= S_CF;
				S_CF:    state_q <= S_CF2;
				S_CF2:   state_q <= S_PCHK;
				S_PCHK:  state_q <= (pass_q == cnt_q) ? S_FIN : S_P0;
				S_P0:    state_q <= S_P1;
				S_P1:    state_q <= S_P2;
				S_P2:    state_q <= S_P3;
				S_P3:    state_q <= S_P4;
				S_P4:    state_q <= S_P5;
				S_P5:    state_q <= S_P6;
				S_P6:    state_q <= S_P7;
				S_P7:    state_q <= S_P8;
				S_P8:    state_q <= p8_bad ? S_FIN : S_COR;
				S_COR: begin
					if (stage_q == nkx_pkg::STAGE_W'(nkx_pkg::CORDIC_STAGES - 1)) begin
						state_q <= S_XM0;
					end
				end
				S_XM0:   state_q <= S_XM1;
				S_XM1:   state_q <= S_XM2;
				S_XM2:   state_q <= S_LW1;
				S_LW1:   if (!log_busy) state_q <= S_LW2;
				S_LW2:   if (!log_busy) state_q <= S_SN0;
				S_SN0:   state_q <= S_SN1;
				S_SN1:   state_q <= S_SN2;
				S_SN2:   state_q <= S_SN3;
				S_SN3:   state_q <= S_SN4;
				S_SN4:   state_q <= S_PCHK;
				S_FIN:   if (fin_go) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		prod_q <= ma * mb;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					fq_q     <= frequency;
					amp_q    <= amplitude;
					n_q      <= n_start;
					k_q      <= k_start;
					ph_sum_q <= nkx_pkg::sat32(66'(phase) + 66'(poff_q));
					cnt_q    <= (iter_q > nkx_pkg::ITER_LIMIT) ? nkx_pkg::ITER_LIMIT : iter_q;
					bad_q    <= 1'b0;
				end
			end
			S_AS:   tf_q <= prod_q[61:0];
			S_DC:   as_q <= prod_q[61:0];
			S_BDIV: dneg_q <= prod_q[65];
			S_BWAIT: begin
				if (!div_busy) begin
					if (thick_q == 31'd0) begin
						base_q <= nkx_pkg::ONE_Q16;
					end else begin
						base_q <= nkx_pkg::sat32((dneg_q ? -$signed(66'(div_quot))
							: $signed(66'(div_quot))) + 66'(nkx_pkg::ONE_Q16));
					end
					if (in_bad) begin
						bad_q <= 1'b1;
					end
				end
			end
			S_FWAIT: ln_amp_q <= log_res;
			S_CF2: begin
				cf24_q <= prod_q[60:24];
				pass_q <= '0;
			end
			S_P1: sq_q <= mulq_p;
			S_P2: kk_q <= mulq_p;
			S_P3: begin
				a_q  <= mulq_p;
				dd_q <= nkx_pkg::sat32(66'(kk_q) + 66'(sq_q));
			end
			S_P4: pr_q <= nkx_pkg::sat32(66'(a_q) + 66'(mulq_p));
			S_P5: b_q <= nkx_pkg::sat32(66'(kk_q) + 66'(mulq_p) - 66'(nkx_pkg::ONE_Q16));
			S_P7: qi_q <= mulq_p;
			S_P8: begin
				if (p8_bad) begin
					bad_q <= 1'b1;
				end
				// move the vector into the right half plane before the rotations
				if (pr_q[31]) begin
					cx_q <= -36'(pr_q);
					cy_q <= -36'(qi_q);
					cz_q <= qi_q[31] ? -nkx_pkg::PI_Q30 : nkx_pkg::PI_Q30;
				end else begin
					cx_q <= 36'(pr_q);
					cy_q <= 36'(qi_q);
					cz_q <= '0;
				end
				stage_q <= '0;
			end
			S_COR: begin
				if (!cy_q[35]) begin
					cx_q <= cx_q + cys;
					cy_q <= cy_q - cxs;
					cz_q <= cz_q + cat;
				end else begin
					cx_q <= cx_q - cys;
					cy_q <= cy_q + cxs;
					cz_q <= cz_q - cat;
				end
				stage_q <= stage_q + 1'b1;
			end
			S_XM1: acc_q <= prod_q[63:0];
			S_XM2: xmk_q <= acc_q + {prod_q[31:0], 32'b0};
			S_LW1: if (!log_busy) lndd_q <= log_res;
			S_LW2: begin
				if (!log_busy) begin
					argd_q <= nkx_pkg::sat32(66'(ph_sum_q) - 66'(cz_q >>> 14));
					kd_q   <= nkx_pkg::sat32(66'(log_res) - (66'(lndd_q) <<< 1)
						- 66'(ln_amp_q));
				end
			end
			S_SN1: acc_q <= 64'(prod_q[62:24]);
			S_SN2: n_q <= nkx_pkg::sat32(66'(s24(r48, argd_q[31])) + 66'(nkx_pkg::ONE_Q16));
			S_SN3: acc_q <= 64'(prod_q[62:24]);
			S_SN4: begin
				k_q    <= s24(r48, kd_q[31]);
				pass_q <= pass_q + 7'd1;
			end
			S_FIN: begin
				if (fin_go) begin
					if (bad_q || n_q < nkx_pkg::ONE_Q16) begin
						n_out_q <= base_q;
						k_out_q <= '0;
						fb_q    <= 1'b1;
					end else begin
						n_out_q <= n_q;
						k_out_q <= k_q;
						fb_q    <= 1'b0;
					end
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_idle_units: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (!div_busy && !log_busy))
		else $error("shared unit still busy while idle");

	a_fallback_k: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && fell_back) |-> (k_out == 32'sd0))
		else $error("fallback result with nonzero k");

	a_refined_n: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !fell_back) |-> (n_out >= nkx_pkg::ONE_Q16))
		else $error("refined n below one without fallback");

	a_pass_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PCHK) |-> (pass_q <= cnt_q))
		else $error("iteration counter past its limit");

	a_fin_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && fin_go) |=> out_valid)
		else $error("finished point not presented");
`endif

endmodule
`default_nettype wire

/* verif/nk_iterative_extraction_tb.sv */
// Testbench for the n/k extraction block: directed and random points, bit-exact predictor.
`default_nettype none
module nk_iterative_extraction_tb;

	localparam longint ONE = 65536;
	localparam longint C1 = 683552635;
	localparam longint CDC = 128758825;
	localparam longint LN2 = 11629080;
	localparam longint KINV = 652032874;
	localparam longint PI30 = 64'sd3373259426;
	localparam int MAX_ITERS = 64;
	localparam int STAGES = 24;
	localparam longint CYCLE_LIMIT = 40_000_000;

	typedef struct {
		logic [30:0]        freq;
		logic [30:0]        amp;
		logic signed [31:0] ph;
		logic signed [31:0] n0;
		logic signed [31:0] k0;
	} point_t;

	typedef struct {
		logic signed [31:0] n;
		logic signed [31:0] k;
		logic               fb;
	} nk_result_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [30:0] frequency;
	logic [30:0] amplitude;
	logic signed [31:0] phase;
	logic signed [31:0] n_start;
	logic signed [31:0] k_start;
	logic out_valid;
	logic out_ready;
	logic signed [31:0] n_out;
	logic signed [31:0] k_out;
	logic fell_back;

	nk_iterative_extraction dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .frequency(frequency),
		.amplitude(amplitude), .phase(phase), .n_start(n_start), .k_start(k_start),
		.out_valid(out_valid), .out_ready(out_ready), .n_out(n_out), .k_out(k_out),
		.fell_back(fell_back)
	);

	// Register copies kept by the predictor
	longint          reg_dc;
	longint unsigned reg_thick;
	longint unsigned reg_scale;
	longint          reg_offset;
	longint unsigned reg_iters;

	nk_result_t nk_expected[$];
	int     mismatches;
	bit     quiet;
	int     hold_cycles;
	longint cycles;

	longint atan_q30_tab[32] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
		64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
		64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
		64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
		64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
		64'h0000001F, 64'h0000000F, 64'h00000007, 64'h00000003, 64'h00000001,
		64'h0, 64'h0
	};

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint qmul(longint a, longint b);
		return clamp32((a * b) >>> 16);
	endfunction

	// natural log of v * 2^-fb in Q16.16 through log2 by repeated squaring
	function automatic longint ln_q16(longint unsigned v, int fb);
		int lead;
		longint unsigned w;
		longint unsigned m;
		longint frac;
		longint l2;
		lead = 0;
		w = v;
		frac = 0;
		while (w > 1) begin
			w = w >> 1;
			lead++;
		end
		m = (lead >= 30) ? (v >> (lead - 30)) : (v << (30 - lead));
		for (int s = 0; s < 30; s++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= (64'd2 << 30)) begin
				m = m >> 1;
				frac = frac | 1;
			end
		end
		l2 = longint'(lead - fb) * (64'sd1 <<< 30) + frac;
		return (l2 * LN2) >>> 38;
	endfunction

	function automatic longint cordic_mag(longint x, longint y, output longint ang);
		longint z;
		longint nx;
		z = 0;
		if (x < 0) begin
			z = (y >= 0) ? PI30 : -PI30;
			x = -x;
			y = -y;
		end
		for (int s = 0; s < STAGES && s < 32; s++) begin
			if (y >= 0) begin
				nx = x + (y >>> s);
				y = y - (x >>> s);
				z += atan_q30_tab[s];
			end else begin
				nx = x - (y >>> s);
				y = y + (x >>> s);
				z -= atan_q30_tab[s];
			end
			x = nx;
		end
		ang = z;
		return x;
	endfunction

	// truncate toward zero, then saturate
	function automatic longint coef_scale(longint unsigned cf24, longint b);
		bit neg;
		longint unsigned mag;
		longint unsigned r;
		neg = b < 0;
		mag = neg ? longint'(-b) : b;
		r = (((cf24 >> 32) * mag) << 8) + (((cf24 & 64'hFFFFFFFF) * mag) >> 24);
		if (!neg) return (r > 64'd2147483647) ? 64'sd2147483647 : longint'(r);
		return (r > 64'h80000000) ? -64'sd2147483648 : -longint'(r);
	endfunction

	function automatic nk_result_t predict_nk(point_t p);
		longint unsigned fq, amp, tf, as_prod, ftq, cf24, cnt;
		longint phs, cur_n, cur_k, base, ln_amp, ph_sum;
		longint onep, sq, kk, dd, pr, qi, ang, xm, lmod;
		bit bad;
		nk_result_t r;
		fq = 64'(p.freq);
		amp = 64'(p.amp);
		phs = 64'(p.ph);
		cur_n = 64'(p.n0);
		cur_k = 64'(p.k0);
		tf = reg_thick * fq;
		as_prod = amp * reg_scale;
		base = ONE;
		bad = 0;
		if (reg_thick != 0)
			base = clamp32(ONE + (reg_dc * CDC) / (longint'(reg_thick) <<< 16));
		if (tf == 0 || as_prod == 0) begin
			bad = 1;
		end else begin
			ftq = (64'd1 << 48) / tf;
			ln_amp = ln_q16(as_prod, 32);
			ph_sum = clamp32(phs + reg_offset);
			if (ftq > 64'd2147483647) ftq = 64'd2147483647;
			cf24 = (longint'(C1) * ftq) >> 24;
			cnt = (reg_iters > MAX_ITERS) ? MAX_ITERS : reg_iters;
			for (longint unsigned pass = 0; pass < cnt; pass++) begin
				onep = clamp32(ONE + cur_n);
				sq = qmul(onep, onep);
				kk = qmul(cur_k, cur_k);
				dd = clamp32(kk + sq);
				pr = clamp32(qmul(cur_n, sq) + qmul(kk, clamp32(2 * ONE + cur_n)));
				qi = qmul(cur_k, clamp32(kk + qmul(cur_n, cur_n) - ONE));
				if (dd <= 0 || (pr == 0 && qi == 0)) begin
					bad = 1;
					break;
				end
				xm = cordic_mag(pr, qi, ang);
				lmod = ln_q16(longint'(xm) * KINV, 44) - 2 * ln_q16(dd, 16);
				cur_n = clamp32(ONE + coef_scale(cf24, clamp32(ph_sum - (ang >>> 14))));
				cur_k = coef_scale(cf24, clamp32(lmod - ln_amp));
			end
		end
		if (!bad && cur_n < ONE) bad = 1;
		if (bad) begin
			cur_n = base;
			cur_k = 0;
		end
		r.n = cur_n[31:0];
		r.k = cur_k[31:0];
		r.fb = bad;
		return r;
	endfunction

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Compare every output transfer against the oldest expectation
	always @(posedge clk) begin
		nk_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (nk_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result n=%0d k=%0d fb=%0d", n_out, k_out, fell_back);
			end else begin
				e = nk_expected.pop_front();
				if (n_out !== e.n || k_out !== e.k || fell_back !== e.fb) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp n=%0d k=%0d fb=%0d, got n=%0d k=%0d fb=%0d",
							e.n, e.k, e.fb, n_out, k_out, fell_back);
				end
			end
		end
	end

	// Result side: random stalls, plus one long hold-off when asked
	initial begin
		int stall;
		out_ready = 0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = (quiet || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
			if (hold_cycles > 0) begin
				out_ready <= 0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end else if (stall > 0) begin
				out_ready <= 0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic write_reg(nkx_pkg::reg_index_t idx, logic [31:0] data);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		case (idx)
			nkx_pkg::REG_DC_TERM:         reg_dc = longint'(signed'(data));
			nkx_pkg::REG_THICKNESS:       reg_thick = 64'(data[30:0]);
			nkx_pkg::REG_AMPLITUDE_SCALE: reg_scale = 64'(data[30:0]);
			nkx_pkg::REG_PHASE_OFFSET:    reg_offset = longint'(signed'(data));
			nkx_pkg::REG_ITERATION_COUNT: reg_iters = 64'(data[6:0]);
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic send_point(point_t p);
		int gap;
		gap = (quiet || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		frequency <= p.freq;
		amplitude <= p.amp;
		phase <= p.ph;
		n_start <= p.n0;
		k_start <= p.k0;
		do @(posedge clk); while (!in_ready);
		nk_expected.push_back(predict_nk(p));
	endtask

	task automatic drain();
		in_valid <= 0;
		while (nk_expected.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic point_t mk_point(longint f, longint a, longint ph, longint n0,
			longint k0);
		point_t p;
		p.freq = f[30:0];
		p.amp = a[30:0];
		p.ph = ph[31:0];
		p.n0 = n0[31:0];
		p.k0 = k0[31:0];
		return p;
	endfunction

	function automatic point_t rand_point();
		point_t p;
		if ($urandom_range(0, 3) != 0) begin
			// physically plausible point
			p.freq = 31'($urandom_range(1 << 12, 1 << 20));
			p.amp = 31'($urandom_range(1, 1 << 17));
			p.ph = $signed($urandom_range(0, 823548)) - 411774;
			p.n0 = $urandom_range(ONE, 4 * ONE);
			p.k0 = $urandom_range(0, ONE);
		end else begin
			p.freq = ($urandom_range(0, 7) == 0) ? 31'd0 : 31'($urandom);
			p.amp = ($urandom_range(0, 7) == 0) ? 31'd0 : 31'($urandom);
			p.ph = $urandom;
			p.n0 = $urandom;
			p.k0 = $urandom;
		end
		return p;
	endfunction

	task automatic test_defaults();
		send_point(mk_point(ONE, ONE / 2, 6554, 2 * ONE, 6554));
		send_point(mk_point(0, ONE, 0, 2 * ONE, 0));
		send_point(mk_point(ONE, 0, 0, 2 * ONE, 0));
		send_point(mk_point(64'h7FFFFFFF, 64'h7FFFFFFF, 64'h7FFFFFFF, 64'h7FFFFFFF,
			64'h7FFFFFFF));
		send_point(mk_point(1, 1, -64'sd2147483648, -64'sd2147483648, -64'sd2147483648));
		send_point(mk_point(ONE, ONE, 0, -ONE, 0));
		send_point(mk_point(ONE, ONE, 0, 0, 0));
		send_point(mk_point(1 << 18, 1 << 10, -411774, 3 * ONE, ONE));
		drain();
	endtask

	task automatic test_iteration_extremes();
		write_reg(nkx_pkg::REG_ITERATION_COUNT, 0);
		send_point(mk_point(ONE, ONE, 0, 2 * ONE, ONE));
		send_point(mk_point(ONE, ONE, 0, ONE / 2, ONE));
		send_point(mk_point(0, ONE, 0, 2 * ONE, ONE));
		drain();
		write_reg(nkx_pkg::REG_ITERATION_COUNT, MAX_ITERS);
		send_point(mk_point(1 << 17, 1 << 15, 100000, 2 * ONE, ONE / 4));
		send_point(rand_point());
		drain();
		write_reg(nkx_pkg::REG_ITERATION_COUNT, 127);
		send_point(mk_point(1 << 16, 1 << 16, -100000, 3 * ONE / 2, ONE / 8));
		drain();
	endtask

	task automatic test_register_extremes();
		write_reg(nkx_pkg::REG_ITERATION_COUNT, 2);
		write_reg(nkx_pkg::REG_DC_TERM, 32'h7FFFFFFF);
		write_reg(nkx_pkg::REG_THICKNESS, 1);
		write_reg(nkx_pkg::REG_AMPLITUDE_SCALE, 1);
		write_reg(nkx_pkg::REG_PHASE_OFFSET, 32'h7FFFFFFF);
		send_point(mk_point(ONE, ONE, ONE, 2 * ONE, 0));
		send_point(rand_point());
		drain();
		write_reg(nkx_pkg::REG_DC_TERM, 32'h80000000);
		write_reg(nkx_pkg::REG_THICKNESS, 32'h7FFFFFFF);
		write_reg(nkx_pkg::REG_AMPLITUDE_SCALE, 32'h7FFFFFFF);
		write_reg(nkx_pkg::REG_PHASE_OFFSET, 32'h80000000);
		send_point(mk_point(64'h7FFFFFFF, 64'h7FFFFFFF, 0, 2 * ONE, ONE));
		send_point(mk_point(1, 1, 0, 2 * ONE, ONE));
		drain();
	endtask

	task automatic random_config();
		write_reg(nkx_pkg::REG_DC_TERM, $urandom);
		write_reg(nkx_pkg::REG_THICKNESS, ($urandom_range(0, 3) != 0) ?
			$urandom_range(1 << 12, 1 << 18) : $urandom_range(1, 32'h7FFFFFFF));
		write_reg(nkx_pkg::REG_AMPLITUDE_SCALE, ($urandom_range(0, 3) != 0) ?
			$urandom_range(1 << 14, 1 << 18) : $urandom_range(1, 32'h7FFFFFFF));
		write_reg(nkx_pkg::REG_PHASE_OFFSET, ($urandom_range(0, 3) != 0) ?
			$signed($urandom_range(0, 411774)) - 205887 : $urandom);
		write_reg(nkx_pkg::REG_ITERATION_COUNT, ($urandom_range(0, 9) != 0) ?
			$urandom_range(0, 4) : $urandom_range(5, 12));
	endtask

	task automatic test_random(int phases, int per_phase);
		for (int ph = 0; ph < phases; ph++) begin
			random_config();
			quiet = (ph == 2);
			for (int i = 0; i < per_phase; i++) send_point(rand_point());
			drain();
		end
		quiet = 0;
	endtask

	// Hold the result side while items keep coming so the input stalls
	task automatic test_backpressure();
		write_reg(nkx_pkg::REG_ITERATION_COUNT, 1);
		hold_cycles = 3000;
		for (int i = 0; i < 8; i++) send_point(rand_point());
		drain();
	endtask

	initial begin
		clk = 0;
		arst_n = 0;
		cfg_valid = 0;
		cfg_index = nkx_pkg::REG_DC_TERM;
		cfg_data = 0;
		in_valid = 0;
		frequency = 0;
		amplitude = 0;
		phase = 0;
		n_start = 0;
		k_start = 0;
		mismatches = 0;
		quiet = 0;
		hold_cycles = 0;
		cycles = 0;
		reg_dc = 0;
		reg_thick = ONE;
		reg_scale = ONE;
		reg_offset = 0;
		reg_iters = 8;
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1;
		@(posedge clk);

		test_defaults();
		test_iteration_extremes();
		test_register_extremes();
		test_backpressure();
		test_random(11, 130);

		drain();
		if (mismatches == 0 && nk_expected.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire
